### hw/rtl/tod_pkg.sv
// Shared types and constants for the time-of-day counter with button adjust.
// Used by tod_cfg_regs, tod_adjust and time_of_day_with_button_adjust.
`default_nettype none

package tod_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_REPEAT_THRESHOLD = 8'd0;
    localparam logic [7:0] REG_FAST_STEP        = 8'd1;
    localparam logic [7:0] REG_BRIGHT_LEVEL_A   = 8'd2;
    localparam logic [7:0] REG_BRIGHT_LEVEL_B   = 8'd3;
    localparam logic [7:0] REG_BRIGHT_LEVEL_C   = 8'd4;
    localparam logic [7:0] REG_BRIGHT_LEVEL_D   = 8'd5;

    // Configuration reset values
    localparam logic [7:0] RST_REPEAT_THRESHOLD = 8'd250;
    localparam logic [5:0] RST_FAST_STEP        = 6'd20;
    localparam logic [3:0] RST_LEVEL_A          = 4'd0;
    localparam logic [3:0] RST_LEVEL_B          = 4'd2;
    localparam logic [3:0] RST_LEVEL_C          = 4'd6;
    localparam logic [3:0] RST_LEVEL_D          = 4'd15;

    // Time limits
    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [7:0] HOLD_MAX   = 8'hFF;

    // State reset values
    localparam logic [5:0] RST_SEC    = 6'd5;
    localparam logic [5:0] RST_MIN    = 6'd40;
    localparam logic [4:0] RST_HOUR   = 5'd7;
    localparam logic [7:0] RST_DAY    = 8'd0;
    localparam logic [7:0] RST_HOLD   = 8'd0;
    localparam logic [1:0] RST_BIDX   = 2'd3;
    localparam logic [7:0] RST_SHOWN  = 8'd200;

    typedef struct packed {
        logic [7:0]      repeat_threshold;
        logic [5:0]      fast_step;
        logic [3:0][3:0] level;
    } tod_cfg_t;

    typedef struct packed {
        logic tick;
        logic fwd;
        logic back;
        logic bright;
    } tod_keys_t;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [7:0] day;
        logic [7:0] hold;
        logic [1:0] bidx;
        logic [7:0] shown;
    } tod_state_t;

    typedef struct packed {
        logic [3:0] level;
        logic       changed;
        logic       redraw;
    } tod_flags_t;

endpackage

`default_nettype wire

### hw/rtl/time_of_day_with_button_adjust.sv
// Time-of-day counter with button adjust: input register, next-state logic,
// result register. Depends on tod_pkg, tod_cfg_regs and tod_adjust.
// A request goes into the input register, its result into the result register.
// Throughput: one request per cycle while m_axis_tready holds; the time state
// updates as a request moves from the input register to the result register.
// Reset: synchronous, active low; empties both stages, loads reset time and registers.
`default_nettype none

module time_of_day_with_button_adjust (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] second_tick, [1] key_forward, [2] key_backward, [3] key_bright
    input  wire logic [7:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [5:0] seconds_now, [11:6] minutes_now, [16:12] hours_now,
    // [24:17] day_now, [28:25] bright_level, [29] bright_changed, [30] redraw
    output logic [31:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    tod_pkg::tod_cfg_t   cfg;
    tod_pkg::tod_keys_t  in_keys_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;
    logic [31:0]         out_data_next;
    tod_pkg::tod_state_t state_reg;
    tod_pkg::tod_state_t state_next;
    tod_pkg::tod_flags_t flags;
    logic                advance;

    tod_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tod_adjust u_adjust (
        .cur   (state_reg),
        .cfg   (cfg),
        .keys  (in_keys_reg),
        .nxt   (state_next),
        .flags (flags)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign out_data_next = {1'b0, flags.redraw, flags.changed, flags.level,
                            state_next.day, state_next.hour, state_next.min,
                            state_next.sec};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.sec   <= tod_pkg::RST_SEC;
            state_reg.min   <= tod_pkg::RST_MIN;
            state_reg.hour  <= tod_pkg::RST_HOUR;
            state_reg.day   <= tod_pkg::RST_DAY;
            state_reg.hold  <= tod_pkg::RST_HOLD;
            state_reg.bidx  <= tod_pkg::RST_BIDX;
            state_reg.shown <= tod_pkg::RST_SHOWN;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_keys_reg.tick   <= s_axis_tdata[0];
            in_keys_reg.fwd    <= s_axis_tdata[1];
            in_keys_reg.back   <= s_axis_tdata[2];
            in_keys_reg.bright <= s_axis_tdata[3];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tod_cfg_regs.sv
// Configuration register file: repeat threshold, fast step, brightness table.
// Depends on tod_pkg.
`default_nettype none

module tod_cfg_regs (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_index,
    input  wire logic [7:0]       cfg_data,
    output tod_pkg::tod_cfg_t     cfg
);

    tod_pkg::tod_cfg_t cfg_reg;
    tod_pkg::tod_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tod_pkg::REG_REPEAT_THRESHOLD: cfg_next.repeat_threshold = cfg_data;
                tod_pkg::REG_FAST_STEP:        cfg_next.fast_step = cfg_data[5:0];
                tod_pkg::REG_BRIGHT_LEVEL_A:   cfg_next.level[0] = cfg_data[3:0];
                tod_pkg::REG_BRIGHT_LEVEL_B:   cfg_next.level[1] = cfg_data[3:0];
                tod_pkg::REG_BRIGHT_LEVEL_C:   cfg_next.level[2] = cfg_data[3:0];
                tod_pkg::REG_BRIGHT_LEVEL_D:   cfg_next.level[3] = cfg_data[3:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_threshold <= tod_pkg::RST_REPEAT_THRESHOLD;
            cfg_reg.fast_step        <= tod_pkg::RST_FAST_STEP;
            cfg_reg.level[0]         <= tod_pkg::RST_LEVEL_A;
            cfg_reg.level[1]         <= tod_pkg::RST_LEVEL_B;
            cfg_reg.level[2]         <= tod_pkg::RST_LEVEL_C;
            cfg_reg.level[3]         <= tod_pkg::RST_LEVEL_D;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tod_adjust.sv
// Next-state logic: tick and button steps with carry/borrow, hold count,
// brightness index and redraw. Depends on tod_pkg.
`default_nettype none

module tod_adjust (
    input  wire tod_pkg::tod_state_t cur,
    input  wire tod_pkg::tod_cfg_t   cfg,
    input  wire tod_pkg::tod_keys_t  keys,
    output tod_pkg::tod_state_t      nxt,
    output tod_pkg::tod_flags_t      flags
);

    logic              fast;
    logic [6:0]        step;
    logic [6:0]        fwd_amt;
    logic [6:0]        bwd_amt;
    logic signed [7:0] delta;
    logic              go_back;
    logic [7:0]        neg_delta;
    logic [6:0]        mag;

    logic [6:0] s_sum;
    logic [5:0] sec_f;
    logic [1:0] mc;
    logic [6:0] m_sum;
    logic [5:0] min_f;
    logic       hc;
    logic [4:0] hour_f;
    logic [7:0] day_f;

    logic [7:0] sec_w;
    logic [5:0] sec_b;
    logic [1:0] mb;
    logic [6:0] min_w;
    logic [5:0] min_b;
    logic       hb;
    logic [4:0] hour_b;
    logic [7:0] day_b;

    // Net seconds of tick plus button step; time counts are always in range,
    // so tick and step combine into one signed move.
    always_comb begin
        fast      = cur.hold > cfg.repeat_threshold;
        step      = fast ? {1'b0, cfg.fast_step} : 7'd1;
        fwd_amt   = keys.fwd ? step : 7'd0;
        bwd_amt   = (!keys.fwd && keys.back) ? step : 7'd0;
        delta     = $signed({7'd0, keys.tick}) + $signed({1'b0, fwd_amt})
                    - $signed({1'b0, bwd_amt});
        go_back   = delta[7];
        neg_delta = 8'd0 - delta;
        mag       = go_back ? neg_delta[6:0] : delta[6:0];
    end

    // Forward with carry
    always_comb begin
        s_sum = {1'b0, cur.sec} + mag;
        if (s_sum >= 7'd120) begin
            sec_f = 6'(s_sum - 7'd120);
            mc    = 2'd2;
        end else if (s_sum >= 7'd60) begin
            sec_f = 6'(s_sum - 7'd60);
            mc    = 2'd1;
        end else begin
            sec_f = s_sum[5:0];
            mc    = 2'd0;
        end
        m_sum = {1'b0, cur.min} + {5'd0, mc};
        if (m_sum > {1'b0, tod_pkg::MIN_LAST}) begin
            min_f = 6'(m_sum - 7'd60);
            hc    = 1'b1;
        end else begin
            min_f = m_sum[5:0];
            hc    = 1'b0;
        end
        hour_f = cur.hour;
        day_f  = cur.day;
        if (hc) begin
            if (cur.hour == tod_pkg::HOUR_LAST) begin
                hour_f = 5'd0;
                day_f  = cur.day + 8'd1;
            end else begin
                hour_f = cur.hour + 5'd1;
            end
        end
    end

    // Backward with borrow
    always_comb begin
        sec_w = {2'd0, cur.sec};
        if ({1'b0, mag} <= sec_w) begin
            sec_b = 6'(sec_w - {1'b0, mag});
            mb    = 2'd0;
        end else if ({1'b0, mag} <= sec_w + 8'd60) begin
            sec_b = 6'(sec_w + 8'd60 - {1'b0, mag});
            mb    = 2'd1;
        end else begin
            sec_b = 6'(sec_w + 8'd120 - {1'b0, mag});
            mb    = 2'd2;
        end
        min_w = {1'b0, cur.min};
        if (min_w >= {5'd0, mb}) begin
            min_b = 6'(min_w - {5'd0, mb});
            hb    = 1'b0;
        end else begin
            min_b = 6'(min_w + 7'd60 - {5'd0, mb});
            hb    = 1'b1;
        end
        hour_b = cur.hour;
        day_b  = cur.day;
        if (hb) begin
            if (cur.hour == 5'd0) begin
                hour_b = tod_pkg::HOUR_LAST;
                day_b  = cur.day - 8'd1;
            end else begin
                hour_b = cur.hour - 5'd1;
            end
        end
    end

    always_comb begin
        nxt           = cur;
        flags.changed = 1'b0;
        if (go_back) begin
            nxt.sec  = sec_b;
            nxt.min  = min_b;
            nxt.hour = hour_b;
            nxt.day  = day_b;
        end else begin
            nxt.sec  = sec_f;
            nxt.min  = min_f;
            nxt.hour = hour_f;
            nxt.day  = day_f;
        end
        priority if (keys.fwd || keys.back) begin
            if (!fast && cur.hold != tod_pkg::HOLD_MAX) begin
                nxt.hold = cur.hold + 8'd1;
            end
        end else if (keys.bright) begin
            if (cur.hold == 8'd0) begin
                nxt.hold      = 8'd1;
                nxt.bidx      = cur.bidx + 2'd1;
                flags.changed = 1'b1;
            end
        end else begin
            nxt.hold = 8'd0;
        end
        flags.redraw = {2'd0, nxt.sec} != cur.shown;
        nxt.shown    = {2'd0, nxt.sec};
        flags.level  = cfg.level[nxt.bidx];
    end

endmodule

`default_nettype wire

### tb/tb_time_of_day_with_button_adjust.sv
// Testbench for time_of_day_with_button_adjust: directed and random button requests
// are checked field by field against a cycle-free model of the clock and brightness.
// Depends on tod_pkg and the time_of_day_with_button_adjust RTL.
`timescale 1ns / 100ps

module tb_time_of_day_with_button_adjust;

    localparam logic [7:0] REG_NONE_LOW  = 8'd6;
    localparam logic [7:0] REG_NONE_HIGH = 8'hFF;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [7:0] day;
        logic [3:0] level;
        logic       changed;
        logic       redraw;
    } display_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] second_tick, [1] key_forward, [2] key_backward, [3] key_bright
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [5:0] seconds_now, [11:6] minutes_now, [16:12] hours_now,
    // [24:17] day_now, [28:25] bright_level, [29] bright_changed, [30] redraw
    logic [31:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index     = 8'd0;
    logic [7:0]  cfg_data      = 8'd0;

    tod_pkg::tod_state_t clock_st;
    tod_pkg::tod_cfg_t   clock_cfg;
    display_t            expected_display_q[$];
    int                  err_count   = 0;
    bit                  src_steady  = 1'b0;
    bit                  sink_steady = 1'b0;
    int                  sink_hold   = 0;
    int                  sink_stall  = 0;

    time_of_day_with_button_adjust u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [7:0] pack_keys(logic tick, logic fwd, logic back, logic brt);
        logic [3:0] junk;
        junk = 4'($urandom);
        return {junk, brt, back, fwd, tick};
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic void reset_clock_model();
        clock_cfg.repeat_threshold = tod_pkg::RST_REPEAT_THRESHOLD;
        clock_cfg.fast_step        = tod_pkg::RST_FAST_STEP;
        clock_cfg.level[0]         = tod_pkg::RST_LEVEL_A;
        clock_cfg.level[1]         = tod_pkg::RST_LEVEL_B;
        clock_cfg.level[2]         = tod_pkg::RST_LEVEL_C;
        clock_cfg.level[3]         = tod_pkg::RST_LEVEL_D;
        clock_st.sec   = tod_pkg::RST_SEC;
        clock_st.min   = tod_pkg::RST_MIN;
        clock_st.hour  = tod_pkg::RST_HOUR;
        clock_st.day   = tod_pkg::RST_DAY;
        clock_st.hold  = tod_pkg::RST_HOLD;
        clock_st.bidx  = tod_pkg::RST_BIDX;
        clock_st.shown = tod_pkg::RST_SHOWN;
    endfunction

    function automatic void apply_register(logic [7:0] idx, logic [7:0] val);
        case (idx)
            tod_pkg::REG_REPEAT_THRESHOLD: clock_cfg.repeat_threshold = val;
            tod_pkg::REG_FAST_STEP:        clock_cfg.fast_step = val[5:0];
            tod_pkg::REG_BRIGHT_LEVEL_A:   clock_cfg.level[0] = val[3:0];
            tod_pkg::REG_BRIGHT_LEVEL_B:   clock_cfg.level[1] = val[3:0];
            tod_pkg::REG_BRIGHT_LEVEL_C:   clock_cfg.level[2] = val[3:0];
            tod_pkg::REG_BRIGHT_LEVEL_D:   clock_cfg.level[3] = val[3:0];
            default: ;
        endcase
    endfunction

    function automatic void advance_seconds(int n);
        for (int i = 0; i < n; i++) begin
            if (clock_st.sec < tod_pkg::SEC_LAST) begin
                clock_st.sec = clock_st.sec + 6'd1;
            end else begin
                clock_st.sec = 6'd0;
                if (clock_st.min < tod_pkg::MIN_LAST) begin
                    clock_st.min = clock_st.min + 6'd1;
                end else begin
                    clock_st.min = 6'd0;
                    if (clock_st.hour < tod_pkg::HOUR_LAST) begin
                        clock_st.hour = clock_st.hour + 5'd1;
                    end else begin
                        clock_st.hour = 5'd0;
                        clock_st.day  = clock_st.day + 8'd1;
                    end
                end
            end
        end
    endfunction

    function automatic void rewind_seconds(int n);
        for (int i = 0; i < n; i++) begin
            if (clock_st.sec > 6'd0) begin
                clock_st.sec = clock_st.sec - 6'd1;
            end else begin
                clock_st.sec = tod_pkg::SEC_LAST;
                if (clock_st.min > 6'd0) begin
                    clock_st.min = clock_st.min - 6'd1;
                end else begin
                    clock_st.min = tod_pkg::MIN_LAST;
                    if (clock_st.hour > 5'd0) begin
                        clock_st.hour = clock_st.hour - 5'd1;
                    end else begin
                        clock_st.hour = tod_pkg::HOUR_LAST;
                        clock_st.day  = clock_st.day - 8'd1;
                    end
                end
            end
        end
    endfunction

    function automatic void update_clock_model(logic [7:0] req);
        display_t d;
        d.changed = 1'b0;
        if (req[0]) advance_seconds(1);
        if (req[1]) begin
            if (clock_st.hold > clock_cfg.repeat_threshold) begin
                advance_seconds(int'(clock_cfg.fast_step));
            end else begin
                if (clock_st.hold != tod_pkg::HOLD_MAX) clock_st.hold = clock_st.hold + 8'd1;
                advance_seconds(1);
            end
        end else if (req[2]) begin
            if (clock_st.hold > clock_cfg.repeat_threshold) begin
                rewind_seconds(int'(clock_cfg.fast_step));
            end else begin
                if (clock_st.hold != tod_pkg::HOLD_MAX) clock_st.hold = clock_st.hold + 8'd1;
                rewind_seconds(1);
            end
        end else if (req[3]) begin
            if (clock_st.hold == 8'd0) begin
                clock_st.hold = 8'd1;
                clock_st.bidx = clock_st.bidx + 2'd1;
                d.changed     = 1'b1;
            end
        end else begin
            clock_st.hold = 8'd0;
        end
        d.redraw       = ({2'b00, clock_st.sec} != clock_st.shown);
        clock_st.shown = {2'b00, clock_st.sec};
        d.sec   = clock_st.sec;
        d.min   = clock_st.min;
        d.hour  = clock_st.hour;
        d.day   = clock_st.day;
        d.level = clock_cfg.level[clock_st.bidx];
        expected_display_q.push_back(d);
    endfunction

    task automatic report_error(string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic send_req(logic [7:0] req);
        int gap;
        gap = (src_steady || $urandom_range(0, 99) >= 35) ? 0 : pick_gap();
        if (gap > 0) repeat (gap) @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = req;
        do @(posedge aclk); while (!s_axis_tready);
        update_clock_model(req);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_display_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_config(logic [7:0] thr, logic [7:0] step,
                              logic [7:0] la, logic [7:0] lb, logic [7:0] lc, logic [7:0] ld);
        wait_drain();
        cfg_write(tod_pkg::REG_REPEAT_THRESHOLD, thr);
        cfg_write(tod_pkg::REG_FAST_STEP, step);
        cfg_write(tod_pkg::REG_BRIGHT_LEVEL_A, la);
        cfg_write(tod_pkg::REG_BRIGHT_LEVEL_B, lb);
        cfg_write(tod_pkg::REG_BRIGHT_LEVEL_C, lc);
        cfg_write(tod_pkg::REG_BRIGHT_LEVEL_D, ld);
    endtask

    // check each result against the oldest expectation
    always @(posedge aclk) begin
        display_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_display_q.size() == 0) begin
                report_error("result with no request outstanding");
            end else begin
                want = expected_display_q.pop_front();
                check_field("seconds_now", 8'(m_axis_tdata[5:0]), 8'(want.sec));
                check_field("minutes_now", 8'(m_axis_tdata[11:6]), 8'(want.min));
                check_field("hours_now", 8'(m_axis_tdata[16:12]), 8'(want.hour));
                check_field("day_now", m_axis_tdata[24:17], want.day);
                check_field("bright_level", 8'(m_axis_tdata[28:25]), 8'(want.level));
                check_field("bright_changed", 8'(m_axis_tdata[29]), 8'(want.changed));
                check_field("redraw", 8'(m_axis_tdata[30]), 8'(want.redraw));
            end
        end
    end

    // result side: hold off, stall at random, or stay ready
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_axis_tready = 1'b0;
            sink_hold--;
        end else if (sink_steady) begin
            m_axis_tready = 1'b1;
        end else if (sink_stall > 0) begin
            m_axis_tready = 1'b0;
            sink_stall--;
        end else begin
            m_axis_tready = 1'b1;
            if ($urandom_range(0, 99) < 25) sink_stall = pick_gap();
        end
    end

    task automatic test_reset_values();
        send_req(8'h00);
        send_req(8'hF0);
        send_req(pack_keys(1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_button_priority();
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b1));
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b1));
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b0));
        send_req(pack_keys(1'b0, 1'b1, 1'b0, 1'b1));
        send_req(pack_keys(1'b0, 1'b1, 1'b1, 1'b0));
        send_req(pack_keys(1'b0, 1'b0, 1'b1, 1'b0));
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b1));
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b0));
        send_req(pack_keys(1'b1, 1'b0, 1'b1, 1'b1));
        send_req(pack_keys(1'b1, 1'b1, 1'b1, 1'b1));
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b0));
        for (int i = 0; i < 4; i++) begin
            send_req(pack_keys(coin(), 1'b0, 1'b0, 1'b1));
            send_req(pack_keys(coin(), 1'b0, 1'b0, 1'b0));
        end
    endtask

    task automatic test_fast_adjust();
        set_config(8'd2, 8'd30, 8'd1, 8'd5, 8'd9, 8'd14);
        repeat (4) send_req(pack_keys(1'b0, 1'b1, 1'b0, 1'b0));
        send_req(pack_keys(1'b1, 1'b0, 1'b0, 1'b0));
        repeat (4) send_req(pack_keys(1'b0, 1'b0, 1'b1, 1'b0));
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // saturate the hold count, then retune the threshold and step around it
    task automatic test_hold_saturation();
        set_config(8'd255, 8'd0, 8'd15, 8'd0, 8'd15, 8'd0);
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        repeat (258) send_req(pack_keys(coin(), 1'b1, 1'b0, 1'b0));
        wait_drain();
        cfg_write(tod_pkg::REG_REPEAT_THRESHOLD, 8'd254);
        send_req(pack_keys(1'b0, 1'b1, 1'b0, 1'b0));
        send_req(pack_keys(1'b1, 1'b0, 1'b1, 1'b0));
        wait_drain();
        cfg_write(tod_pkg::REG_FAST_STEP, 8'd63);
        send_req(pack_keys(1'b0, 1'b1, 1'b0, 1'b0));
        send_req(pack_keys(1'b0, 1'b0, 1'b1, 1'b0));
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b1));
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b0));
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // walk back across midnight, then forward across it again
    task automatic test_midnight_crossing();
        logic [7:0] start_day;
        int         extra;
        set_config(8'd0, 8'd63, 8'd3, 8'd7, 8'd11, 8'd13);
        start_day = clock_st.day;
        extra = 0;
        while (extra < 12) begin
            send_req(pack_keys(coin(), 1'b0, 1'b1, coin()));
            if (clock_st.day != start_day || extra > 0) extra++;
        end
        start_day = clock_st.day;
        extra = 0;
        while (extra < 12) begin
            send_req(pack_keys(coin(), 1'b1, coin(), coin()));
            if (clock_st.day != start_day || extra > 0) extra++;
        end
        send_req(pack_keys(1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic press_sessions(int count);
        int n;
        int key;
        int len;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 80) begin
                key = $urandom_range(0, 2);
                len = $urandom_range(1, 14);
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0)
                        send_req(pack_keys(coin(), coin(), coin(), coin()));
                    else
                        send_req(pack_keys(coin(), key == 0, key == 1, key == 2));
                end
                repeat ($urandom_range(1, 3)) send_req(pack_keys(coin(), 1'b0, 1'b0, 1'b0));
                n += len;
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) send_req(pack_keys(coin(), coin(), coin(), coin()));
                n += len;
            end
        end
    endtask

    task automatic test_random_sessions();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_config(8'd0, 8'd63, 8'd15, 8'd0, 8'd15, 8'd0);
                1: set_config(8'd255, 8'd0, 8'd0, 8'd15, 8'd0, 8'd15);
                2: set_config(8'd4, 8'd1, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom));
                3: begin
                    set_config(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 12)),
                               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom));
                    cfg_write(REG_NONE_LOW, 8'($urandom));
                    cfg_write(REG_NONE_HIGH, 8'($urandom));
                end
                default: set_config(8'd1, 8'd59, 8'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom));
            endcase
            press_sessions(30);
        end
    endtask

    // hold off the result side while requests keep coming, then pause for drain
    task automatic test_backpressure();
        set_config(8'd3, 8'd17, 8'd2, 8'd4, 8'd8, 8'd12);
        src_steady = 1'b1;
        sink_hold  = 150;
        press_sessions(30);
        src_steady = 1'b0;
        wait_drain();
        press_sessions(10);
    endtask

    initial begin
        #5_000_000;
        $display("** time_of_day_with_button_adjust: FAILED **");
        $finish;
    end

    initial begin
        reset_clock_model();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_values();
        test_button_priority();
        test_fast_adjust();
        test_hold_saturation();
        test_midnight_crossing();
        test_random_sessions();
        test_backpressure();
        wait_drain();
        repeat (8) @(posedge aclk);
        if (err_count == 0 && expected_display_q.size() == 0)
            $display("** time_of_day_with_button_adjust: PASSED **");
        else
            $display("** time_of_day_with_button_adjust: FAILED **");
        $finish;
    end

endmodule
